/* design/gheq_pkg.sv */
`default_nettype none

package gheq_pkg;

  // Gray levels and widths
  localparam int unsigned LEVELS = 256;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CNT_W  = 21;

  // Count phase stops counting pixels once the total reaches this limit
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] COUNT_LIMIT =
    CNT_W'((MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX);

  // Highest table value, used when cumulative equals the total
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Operation codes carried in tuser
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  // Count request into the histogram
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } cnt_req_t;

  // Table write from the build sweep
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] addr;
    logic [PIX_W-1:0] data;
  } map_wr_t;

  // Table lookup for one map pixel
  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] addr;
    logic             last;
  } map_rd_t;

endpackage

`default_nettype wire

/* design/gheq_div.sv */
`default_nettype none

// Serial restoring divider: floor(256 * dividend / divisor), clamped to 255.
// One quotient bit per cycle; the full and empty cases skip the shifts and raise done in the next cycle.
module gheq_div
  import gheq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [PIX_W-1:0]      quotient
);

  localparam int unsigned STEP_W = $clog2(PIX_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    shifted;
  logic              ge;
  logic [CNT_W:0]    rem_step;

  // One shift-and-subtract step; remainder stays below the divisor
  always_comb begin
    shifted  = {rem[CNT_W-1:0], 1'b0};
    ge       = shifted >= {1'b0, dsr};
    rem_step = ge ? (shifted - {1'b0, dsr}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dsr <= divisor;
        if (divisor == '0) begin
          quotient <= '0;
          done     <= 1'b1;
        end else if (dividend >= divisor) begin
          quotient <= PIX_MAX;
          done     <= 1'b1;
        end else begin
          rem  <= {1'b0, dividend};
          busy <= 1'b1;
          step <= '0;
        end
      end else if (busy) begin
        rem      <= rem_step;
        quotient <= {quotient[PIX_W-2:0], ge};
        step     <= step + 1'b1;
        if (step == STEP_W'(PIX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A new division never starts on top of one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (!busy && !done))
    else $error("divider started while busy");

endmodule

`default_nettype wire

/* design/gheq_hist.sv */
`default_nettype none

// Histogram memory with read-modify-write counting and the table build sweep.
// After reset a pass over all 256 bins writes each to zero before counting starts.
module gheq_hist
  import gheq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cnt_req_t req,
  output logic          idle,
  output map_wr_t       map_wr
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_READ,
    ST_ACC,
    ST_DIV
  } state_t;

  state_t state;

  logic [CNT_W-1:0] bin_mem [LEVELS];
  logic [CNT_W-1:0] rd_q;

  logic             rd_en;
  logic [PIX_W-1:0] rd_addr;
  logic             wr_en;
  logic [PIX_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic             count_en;
  logic             s_valid;
  logic [PIX_W-1:0] s_addr;
  logic             w_valid;
  logic [PIX_W-1:0] w_addr;
  logic [CNT_W-1:0] w_data;
  logic [CNT_W-1:0] bump;

  logic [CNT_W-1:0] pixel_total;
  logic [CNT_W-1:0] cum;
  logic [CNT_W-1:0] cum_sum;
  logic [PIX_W-1:0] idx;

  logic             div_done;
  logic [PIX_W-1:0] div_q;

  // Pixels beyond the limit leave bins and total alone
  assign count_en = req.valid && (pixel_total < COUNT_LIMIT);

  // Forward the previous beat's write when the same bin comes back
  assign bump    = ((w_valid && (w_addr == s_addr)) ? w_data : rd_q) + CNT_W'(1);
  assign cum_sum = cum + rd_q;

  // Memory port selection
  always_comb begin
    rd_en   = count_en;
    rd_addr = req.pixel;
    wr_en   = s_valid;
    wr_addr = s_addr;
    wr_data = bump;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = '0;
    end
    if (state == ST_READ) begin
      rd_en   = 1'b1;
      rd_addr = idx;
    end
    if (state == ST_ACC) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = '0;
    end
  end

  // Bin memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= bin_mem[rd_addr];
    end
  end

  // Increment stage and last-write record for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      s_valid <= count_en;
      w_valid <= s_valid;
    end
    s_addr <= req.pixel;
    w_addr <= s_addr;
    w_data <= bump;
  end

  gheq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_ACC),
    .dividend (cum_sum),
    .divisor  (pixel_total),
    .done     (div_done),
    .quotient (div_q)
  );

  // Table entries go out as each division finishes
  always_comb begin
    map_wr.valid = (state == ST_DIV) && div_done;
    map_wr.addr  = idx;
    map_wr.data  = div_q;
  end

  assign idle = (state == ST_IDLE);

  // Count total and build sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      pixel_total <= '0;
      cum         <= '0;
      idx         <= '0;
    end else begin
      if (count_en) begin
        pixel_total <= pixel_total + CNT_W'(1);
      end
      unique case (state)
        ST_CLEAR: begin
          // index wraps back to zero on the last bin
          idx <= idx + 1'b1;
          if (idx == PIX_W'(LEVELS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid && req.last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          idx   <= '0;
          cum   <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          cum   <= cum_sum;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (idx == PIX_W'(LEVELS - 1)) begin
              pixel_total <= '0;
              state       <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // No count beat reaches the histogram during a build
  a_no_count_in_build: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> (state == ST_IDLE))
    else $error("count beat during table build");

  // The total never passes the count limit
  a_total_limit: assert property (@(posedge clk) disable iff (rst)
    pixel_total <= COUNT_LIMIT)
    else $error("pixel total above limit");

  // Increment writes never collide with the sweep
  a_stage_idle: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> ($past(state) == ST_IDLE))
    else $error("increment stage active outside count phase");

endmodule

`default_nettype wire

/* design/gheq_map.sv */
`default_nettype none

// Mapping table memory; its registered read is the output register.
module gheq_map
  import gheq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire map_wr_t          wr,
  input  wire map_rd_t          rd,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel,
  output logic                  out_last
);

  logic [PIX_W-1:0] map_mem [LEVELS];

  // Table memory; a lookup loads the output beat
  always_ff @(posedge clk) begin
    if (wr.valid) begin
      map_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      out_pixel <= map_mem[rd.addr];
      out_last  <= rd.last;
    end
  end

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd.en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Lookups and table writes belong to different phases
  a_rd_wr_apart: assert property (@(posedge clk) disable iff (rst)
    !(rd.en && wr.valid))
    else $error("table lookup during build");

  // A lookup never overwrites a beat that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !rd.en)
    else $error("output beat overwritten");

endmodule

`default_nettype wire

/* design/gray_histogram_equalizer_unit.sv */
`default_nettype none

// Histogram equalization of an 8-bit grayscale region.
// Input stream s_*: tuser is the operation (0 count, 1 map), tdata the pixel,
// tlast marks the final pixel of the phase. Output stream m_*: tdata is the
// equalized pixel, tlast copies the input tlast of that map beat.
// Count beats produce no output and are taken one per cycle while idle; the histogram
// memory does read-modify-write with forwarding between back-to-back beats.
// The count beat with tlast starts a table build: each of the 256 bins is read
// and cleared, then a bit-serial divider forms floor(256*cum/total), clamped to
// 255, while s_tready is low. Each bin passes read, accumulate and divide states;
// the divider skips its shifts when the quotient is full or the total is zero.
// Map beats are taken one per cycle when idle; the result follows in the cycle
// after acceptance, read from the table memory into the output register.
// If m_tready is low, the output beat holds and further map beats wait, while
// count beats are still accepted. Reset empties the total and the output
// register, then a clearing pass zeroes all 256 histogram bins with s_tready
// low; the table is undefined until the first build.
module gray_histogram_equalizer_unit
  import gheq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [PIX_W-1:0] s_tdata,   // [7:0] pixel
  input  wire logic             s_tuser,   // [0] operation
  input  wire logic             s_tlast,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // [7:0] mapped_pixel
  output logic                  m_tlast
);

  logic     hist_idle;
  logic     accept;
  cnt_req_t cnt_req;
  map_rd_t  map_rd;
  map_wr_t  map_wr;

  // Map beats also need room in the output register
  assign s_tready = hist_idle && ((s_tuser == OP_COUNT) || !m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cnt_req.valid = accept && (s_tuser == OP_COUNT);
    cnt_req.pixel = s_tdata;
    cnt_req.last  = s_tlast;
    map_rd.en     = accept && (s_tuser == OP_MAP);
    map_rd.addr   = s_tdata;
    map_rd.last   = s_tlast;
  end

  gheq_hist u_hist (
    .clk    (clk),
    .rst    (rst),
    .req    (cnt_req),
    .idle   (hist_idle),
    .map_wr (map_wr)
  );

  gheq_map u_map (
    .clk       (clk),
    .rst       (rst),
    .wr        (map_wr),
    .rd        (map_rd),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_pixel (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire
